### rtl/core/number_to_ascii_digits_defines.svh
// Assertion macros for the number-to-ASCII digit converter.
`ifndef NUMBER_TO_ASCII_DIGITS_DEFINES_SVH
`define NUMBER_TO_ASCII_DIGITS_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define N2A_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define N2A_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/n2a_pkg.sv
// Shared types, constants and helpers for the number-to-ASCII digit converter.
package n2a_pkg;

  localparam int MAX_DIGITS = 32;
  localparam int DIG_IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 7;
  localparam int MODE_W     = 3;
  localparam int DCNT_W     = 6;
  localparam int CFG_DATA_W = 6;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Reciprocal of ten, scaled by 2^35.
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [CHAR_W-1:0] ASCII_ZERO       = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_LETTER_OFS = 7'd55;
  localparam logic [CHAR_W-1:0] ASCII_MINUS      = 7'h2D;
  localparam logic [CHAR_W-1:0] ASCII_PLUS       = 7'h2B;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A    = 7'h41;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_F    = 7'h46;
  localparam logic [CHAR_W-1:0] ASCII_NINE       = 7'h39;
  localparam logic [3:0]        DEC_MAX_DIGIT    = 4'd9;

  localparam logic [MODE_W-1:0] RESET_RADIX_MODE  = 3'd2;
  localparam logic [DCNT_W-1:0] RESET_DIGIT_COUNT = 6'd10;

  typedef enum logic [MODE_W-1:0] {
    MODE_BIN  = 3'd0,
    MODE_OCT  = 3'd1,
    MODE_DEC  = 3'd2,
    MODE_HEX  = 3'd3,
    MODE_SDEC = 3'd4
  } mode_t;

  typedef enum logic {
    CFG_RADIX_MODE  = 1'b0,
    CFG_DIGIT_COUNT = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    RS_BIN = 2'd0,
    RS_OCT = 2'd1,
    RS_DEC = 2'd2,
    RS_HEX = 2'd3
  } rsel_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SHIFT,
    BK_MUL,
    BK_DIV,
    BK_SIGN,
    BK_EMIT
  } bk_state_t;

  typedef struct packed {
    logic [MODE_W-1:0] radix_mode;
    logic [DCNT_W-1:0] digit_count;
  } cfg_t;

  // One classified value waiting for conversion.
  typedef struct packed {
    logic [VALUE_W-1:0] mag;
    rsel_t              rsel;
    logic               has_sign;
    logic               neg;
    logic [CNT_W-1:0]   ndig;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {{(CHAR_W-4){1'b0}}, d};
    return (d > DEC_MAX_DIGIT) ? (d_ext + ASCII_LETTER_OFS) : (d_ext + ASCII_ZERO);
  endfunction

endpackage

### rtl/core/n2a_front.sv
// Front end: accepts input values and classifies them into conversion descriptors.
module n2a_front
  import n2a_pkg::*;
(
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [VALUE_W-1:0] in_value,
  input  cfg_t               cfg,
  input  fifo_stat_t         fifo_stat,
  output logic               push,
  output desc_t              push_desc
);

  logic             mode_ok;
  logic [CNT_W-1:0] ndig;

  assign in_tready = !fifo_stat.full;

  always_comb begin
    if (cfg.digit_count == '0) begin
      ndig = CNT_W'(1);
    end else if (cfg.digit_count > DCNT_W'(MAX_DIGITS)) begin
      ndig = CNT_W'(MAX_DIGITS);
    end else begin
      ndig = CNT_W'(cfg.digit_count);
    end
  end

  always_comb begin
    mode_ok            = 1'b1;
    push_desc.mag      = in_value;
    push_desc.rsel     = RS_DEC;
    push_desc.has_sign = 1'b0;
    push_desc.neg      = 1'b0;
    push_desc.ndig     = ndig;
    unique case (cfg.radix_mode)
      MODE_BIN: push_desc.rsel = RS_BIN;
      MODE_OCT: push_desc.rsel = RS_OCT;
      MODE_DEC: push_desc.rsel = RS_DEC;
      MODE_HEX: push_desc.rsel = RS_HEX;
      MODE_SDEC: begin
        push_desc.has_sign = 1'b1;
        push_desc.neg      = in_value[VALUE_W-1];
        // Two's complement magnitude; the most negative value maps onto itself.
        if (in_value[VALUE_W-1]) begin
          push_desc.mag = (~in_value) + VALUE_W'(1);
        end
      end
      default: mode_ok = 1'b0;
    endcase
  end

  // Values in an unused mode are accepted and dropped.
  assign push = in_tvalid && in_tready && mode_ok;

endmodule

### rtl/core/n2a_fifo.sv
// Short descriptor queue between the front end and the conversion back end.
module n2a_fifo
  import n2a_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  desc_t      push_desc,
  input  logic       pop,
  output desc_t      pop_desc,
  output fifo_stat_t stat
);

  desc_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_desc   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + FIFO_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + FIFO_PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + FIFO_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

### rtl/core/n2a_back.sv
// Back end: digit extraction into a buffer, then character output through a register.
module n2a_back
  import n2a_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  fifo_stat_t        fifo_stat,
  input  desc_t             pop_desc,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last
);

  bk_state_t              st_r, st_nxt;
  logic [VALUE_W-1:0]     val_r, val_nxt;
  logic [2*VALUE_W-1:0]   prod_r;
  rsel_t                  rsel_r, rsel_nxt;
  logic                   sign_r, sign_nxt;
  logic                   neg_r, neg_nxt;
  logic [CNT_W-1:0]       ndig_r, ndig_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [DIG_IDX_W-1:0]   idx_r, idx_nxt;
  logic [3:0]             dig_r [MAX_DIGITS];
  logic                   ov_r, ov_nxt;
  logic [CHAR_W-1:0]      oc_r, oc_nxt;
  logic                   ol_r, ol_nxt;

  logic                   slot_free;
  logic [CNT_W-1:0]       cnt_inc;
  logic [3:0]             sh_dig;
  logic [VALUE_W-1:0]     sh_val;
  logic [VALUE_W-RECIP_SHIFT+VALUE_W-1:0] quot;
  logic [3:0]             qx10_lo;
  logic [3:0]             dv_dig;
  logic                   sh_done, dv_done;
  logic                   dig_clr, dig_we;
  logic [3:0]             dig_wdata;

  assign slot_free = !ov_r || out_ready;
  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign out_valid = ov_r;
  assign out_char  = oc_r;
  assign out_last  = ol_r;

  // Power-of-two radix: peel the low digit off with a shift.
  always_comb begin
    sh_dig = '0;
    sh_val = '0;
    unique case (rsel_r)
      RS_BIN: begin
        sh_dig = {3'b000, val_r[0]};
        sh_val = {1'b0, val_r[VALUE_W-1:1]};
      end
      RS_OCT: begin
        sh_dig = {1'b0, val_r[2:0]};
        sh_val = {3'b000, val_r[VALUE_W-1:3]};
      end
      RS_HEX: begin
        sh_dig = val_r[3:0];
        sh_val = {4'b0000, val_r[VALUE_W-1:4]};
      end
      RS_DEC: begin
        sh_dig = '0;
        sh_val = '0;
      end
    endcase
  end

  // Decimal: the quotient comes from the registered reciprocal product, and the
  // remainder needs only the low four bits of quotient times ten.
  assign quot    = prod_r[2*VALUE_W-1:RECIP_SHIFT];
  assign qx10_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
  assign dv_dig  = val_r[3:0] - qx10_lo;

  // Stop early once the remaining value is zero: the buffer was cleared.
  assign sh_done = (cnt_inc == ndig_r) || (sh_val == '0);
  assign dv_done = (cnt_inc == ndig_r) || (quot == '0);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: begin
        if (!fifo_stat.empty) begin
          st_nxt = (pop_desc.rsel == RS_DEC) ? BK_MUL : BK_SHIFT;
        end
      end
      BK_SHIFT: begin
        if (sh_done) begin
          st_nxt = sign_r ? BK_SIGN : BK_EMIT;
        end
      end
      BK_MUL: st_nxt = BK_DIV;
      BK_DIV: begin
        if (dv_done) begin
          st_nxt = sign_r ? BK_SIGN : BK_EMIT;
        end else begin
          st_nxt = BK_MUL;
        end
      end
      BK_SIGN: begin
        if (slot_free) begin
          st_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (slot_free && (idx_r == '0)) begin
          st_nxt = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    val_nxt   = val_r;
    rsel_nxt  = rsel_r;
    sign_nxt  = sign_r;
    neg_nxt   = neg_r;
    ndig_nxt  = ndig_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    dig_clr   = 1'b0;
    dig_we    = 1'b0;
    dig_wdata = '0;
    ov_nxt    = ov_r && !out_ready;
    oc_nxt    = oc_r;
    ol_nxt    = ol_r;
    unique case (st_r)
      BK_IDLE: begin
        if (!fifo_stat.empty) begin
          pop      = 1'b1;
          val_nxt  = pop_desc.mag;
          rsel_nxt = pop_desc.rsel;
          sign_nxt = pop_desc.has_sign;
          neg_nxt  = pop_desc.neg;
          ndig_nxt = pop_desc.ndig;
          cnt_nxt  = '0;
          idx_nxt  = DIG_IDX_W'(pop_desc.ndig - CNT_W'(1));
          dig_clr  = 1'b1;
        end
      end
      BK_SHIFT: begin
        dig_we    = 1'b1;
        dig_wdata = sh_dig;
        val_nxt   = sh_val;
        cnt_nxt   = cnt_inc;
      end
      BK_MUL: begin
      end
      BK_DIV: begin
        dig_we    = 1'b1;
        dig_wdata = dv_dig;
        val_nxt   = VALUE_W'(quot);
        cnt_nxt   = cnt_inc;
      end
      BK_SIGN: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          oc_nxt = neg_r ? ASCII_MINUS : ASCII_PLUS;
          ol_nxt = 1'b0;
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          ov_nxt  = 1'b1;
          oc_nxt  = digit_char(dig_r[idx_r]);
          ol_nxt  = (idx_r == '0);
          idx_nxt = idx_r - DIG_IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    rsel_r <= rsel_nxt;
    sign_r <= sign_nxt;
    neg_r  <= neg_nxt;
    ndig_r <= ndig_nxt;
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
    oc_r   <= oc_nxt;
    ol_r   <= ol_nxt;
    prod_r <= val_r * RECIP_TEN;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (dig_clr) begin
        dig_r[i] <= '0;
      end else if (dig_we && (cnt_r[DIG_IDX_W-1:0] == DIG_IDX_W'(i))) begin
        dig_r[i] <= dig_wdata;
      end
    end
  end

endmodule

### rtl/core/number_to_ascii_digits.sv
// Top level of the number-to-ASCII digit converter: config registers, front end, queue, back end.
//
// Each accepted 32-bit value becomes a run of ASCII characters, most significant first, with
// tlast on the final one. radix_mode selects binary, octal, decimal, upper-case hexadecimal, or
// signed decimal with a leading '+' or '-'; digit_count sets the number of digits (0 acts as 1,
// values above 32 act as 32), keeping leading zeros and dropping higher digits. Values arriving
// in the unused modes 5 to 7 are accepted and produce no output. A front end classifies each
// value and places it in a two-entry queue, so input keeps flowing while the back end works. The
// back end first extracts digits into a buffer, lowest first: a shift per digit for the
// power-of-two radices, and for decimal a reciprocal multiply, then the quotient and remainder,
// stopping as soon as the remaining value is zero. It then sends one character per cycle through
// an output register as long as out_tready stays high, and finishes one value before it takes the
// next. Each value gives as many characters as the digit count, plus one for the sign.
// Configuration should be written only while the block is idle; cfg_ready is always high.
`include "number_to_ascii_digits_defines.svh"

module number_to_ascii_digits
  import n2a_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [VALUE_W-1:0]    in_tdata,   // [31:0] value
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [6:0] ascii_char, [7] zero
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [MODE_W-1:0] radix_mode_r, radix_mode_nxt;
  logic [DCNT_W-1:0] digit_count_r, digit_count_nxt;
  cfg_t              cfg;
  fifo_stat_t        fifo_stat;
  logic              fifo_push;
  logic              fifo_pop;
  desc_t             push_desc;
  desc_t             pop_desc;
  logic [CHAR_W-1:0] out_char;
  logic              out_is_digit;
  logic              out_is_hex;
  logic              out_is_sign;

  assign cfg_ready = 1'b1;

  // Register writes; the data is cut to each register's width.
  always_comb begin
    radix_mode_nxt  = radix_mode_r;
    digit_count_nxt = digit_count_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RADIX_MODE:  radix_mode_nxt  = cfg_data[MODE_W-1:0];
        CFG_DIGIT_COUNT: digit_count_nxt = cfg_data[DCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_mode_r  <= RESET_RADIX_MODE;
      digit_count_r <= RESET_DIGIT_COUNT;
    end else begin
      radix_mode_r  <= radix_mode_nxt;
      digit_count_r <= digit_count_nxt;
    end
  end

  assign cfg.radix_mode  = radix_mode_r;
  assign cfg.digit_count = digit_count_r;

  n2a_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_value  (in_tdata),
    .cfg       (cfg),
    .fifo_stat (fifo_stat),
    .push      (fifo_push),
    .push_desc (push_desc)
  );

  n2a_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_desc (push_desc),
    .pop       (fifo_pop),
    .pop_desc  (pop_desc),
    .stat      (fifo_stat)
  );

  n2a_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_stat (fifo_stat),
    .pop_desc  (pop_desc),
    .pop       (fifo_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_char),
    .out_last  (out_tlast)
  );

  assign out_tdata = {1'b0, out_char};

  // Character classes of the character on the output.
  assign out_is_digit = (out_char >= ASCII_ZERO) && (out_char <= ASCII_NINE);
  assign out_is_hex   = (out_char >= ASCII_UPPER_A) && (out_char <= ASCII_UPPER_F);
  assign out_is_sign  = (out_char == ASCII_PLUS) || (out_char == ASCII_MINUS);

  // The queue is never written when full nor read when empty.
  `N2A_ASSERT_NOW(a_no_push_full, fifo_push, !fifo_stat.full, "descriptor pushed into full queue")
  `N2A_ASSERT_NOW(a_no_pop_empty, fifo_pop, !fifo_stat.empty, "descriptor popped from empty queue")
  // Every character shown is a digit, an upper-case hex letter or a sign.
  `N2A_ASSERT_NOW(a_char_legal, out_tvalid, out_is_digit || out_is_hex || out_is_sign, "illegal char")
  // A sign character never ends a run.
  `N2A_ASSERT_NOW(a_sign_not_last, out_tvalid && out_is_sign, !out_tlast, "sign character marked last")

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the number-to-ASCII digit converter.
`timescale 1ns / 100ps

module tb_top;
  import n2a_pkg::*;

  // Radix modes that the block accepts but turns into no characters.
  localparam logic [MODE_W-1:0] MODE_SPARE5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

  // Start, up to 32 extraction steps and 33 characters, with margin.
  localparam int TAIL_CYCLES  = 120;
  localparam int HOLD_CYCLES  = 600;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int ITEMS_PHASE  = 90;
  localparam int ITEMS_FORMAT = 15;
  localparam int PRINT_LIMIT  = 30;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  // Holds the format registers and the characters still owed by the block.
  class ascii_text_board;
    logic [MODE_W-1:0] radix_mode;
    logic [DCNT_W-1:0] digit_count;
    text_char_t        text_q[$];
    int unsigned       mismatches;

    function new();
      radix_mode  = RESET_RADIX_MODE;
      digit_count = RESET_DIGIT_COUNT;
      mismatches  = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_RADIX_MODE) radix_mode = data[MODE_W-1:0];
      else digit_count = data[DCNT_W-1:0];
    endfunction

    function int pending();
      return text_q.size();
    endfunction

    // Builds the text of one accepted value, most significant character first.
    function void note_value(logic [VALUE_W-1:0] value);
      int unsigned       base, width, rest, d;
      int                i;
      logic [CHAR_W-1:0] digs[MAX_DIGITS];
      logic              signed_fmt;
      logic [CHAR_W-1:0] sign_ch;
      text_char_t        tc;
      signed_fmt = 1'b0;
      sign_ch    = ASCII_PLUS;
      rest       = value;
      case (radix_mode)
        MODE_BIN: base = 2;
        MODE_OCT: base = 8;
        MODE_DEC: base = 10;
        MODE_HEX: base = 16;
        MODE_SDEC: begin
          base       = 10;
          signed_fmt = 1'b1;
          // The most negative value negates onto itself and reads as 2147483648.
          if (value[VALUE_W-1]) begin
            sign_ch = ASCII_MINUS;
            rest    = ~value + 32'd1;
          end
        end
        default: return;
      endcase
      width = digit_count;
      if (width < 1) width = 1;
      if (width > MAX_DIGITS) width = MAX_DIGITS;
      // Places above the value's reach come out as zeros.
      for (i = 0; i < width; i++) begin
        d       = rest % base;
        digs[i] = (d > 9) ? CHAR_W'(d) + ASCII_LETTER_OFS : CHAR_W'(d) + ASCII_ZERO;
        rest    = rest / base;
      end
      if (signed_fmt) begin
        tc.ch   = sign_ch;
        tc.last = 1'b0;
        text_q.push_back(tc);
      end
      for (i = width - 1; i >= 0; i--) begin
        tc.ch   = digs[i];
        tc.last = (i == 0);
        text_q.push_back(tc);
      end
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task check_char(logic [7:0] data, logic last);
      text_char_t want;
      if (text_q.size() == 0) begin
        report($sformatf("character 0x%02h with no text pending", data));
        return;
      end
      want = text_q.pop_front();
      if (data[CHAR_W-1:0] !== want.ch)
        report($sformatf("character 0x%02h, wanted 0x%02h", data[CHAR_W-1:0], want.ch));
      if (data[7] !== 1'b0)
        report("padding bit of out_tdata is set");
      if (last !== want.last)
        report($sformatf("tlast %b, wanted %b", last, want.last));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [VALUE_W-1:0]    in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;   // [6:0] ascii_char, [7] zero
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = CFG_RADIX_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ascii_text_board board = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_trigger = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_cnt = 0;

  number_to_ascii_digits u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever the trigger moves.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_trigger != hold_seen) begin
      hold_seen  <= hold_trigger;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_char(out_tdata, out_tlast);
  end

  // Offers one value, after random idle cycles, and waits for it to be taken.
  task automatic send_value(input logic [VALUE_W-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    board.note_value(value);
  endtask

  // Stops sending and waits until the block has nothing left in flight.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Writes both format registers while the block is idle.
  task automatic set_format(input logic [CFG_DATA_W-1:0] mode_bits,
                            input logic [CFG_DATA_W-1:0] count_bits);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_RADIX_MODE;
    cfg_data  <= mode_bits;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(CFG_RADIX_MODE, mode_bits);
    cfg_index <= CFG_DIGIT_COUNT;
    cfg_data  <= count_bits;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(CFG_DIGIT_COUNT, count_bits);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return $urandom_range(999);
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return '0;
      4:       return $urandom >> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [MODE_W-1:0]     mode_pick;
    logic [CFG_DATA_W-1:0] count_pick;
    int                    phase, sent, block_len, k;
    logic                  spare;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The reset format, ten decimal digits, comes first.
    send_value(32'd0);
    send_value(32'hFFFF_FFFF);
    send_value(32'd1234567890);
    // Hex letters A through F.
    set_format({3'b000, MODE_HEX}, 6'd8);
    send_value(32'h89AB_CDEF);
    send_value(32'hFEDC_BA98);
    set_format({3'b000, MODE_BIN}, 6'd32);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0001);
    // Octal with a count above the limit: saturates to 32, high places are zeros.
    set_format({3'b000, MODE_OCT}, 6'd40);
    send_value(32'hFFFF_FFFF);
    // Signed decimal: most negative value, zero gets '+', extremes.
    set_format({3'b000, MODE_SDEC}, 6'd10);
    send_value(32'h8000_0000);
    send_value(32'd0);
    send_value(32'h7FFF_FFFF);
    send_value(32'hFFFF_FFFF);
    set_format({3'b000, MODE_SDEC}, 6'd1);
    send_value(-32'sd5);
    send_value(32'd12);
    // A digit count of zero acts as one.
    set_format({3'b000, MODE_DEC}, 6'd0);
    send_value(32'd987);
    // Upper data bits of the mode write are dropped; count 63 saturates.
    set_format({3'b111, MODE_DEC}, 6'd63);
    send_value(32'hFFFF_FFFF);
    // Unused modes take values and give nothing back.
    set_format({3'b000, MODE_SPARE5}, 6'd4);
    send_value(32'd55);
    set_format({3'b000, MODE_SPARE6}, 6'd4);
    send_value(32'hFFFF_FFFF);
    set_format({3'b000, MODE_SPARE7}, 6'd4);
    send_value(32'h1234_5678);

    // Random part in four traffic profiles. Each format block ends with a full
    // drain, so the sender regularly pauses until every character is back.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      sent = 0;
      while (sent < ITEMS_PHASE) begin
        spare = ($urandom_range(19) < 2);
        mode_pick = spare ? MODE_W'($urandom_range(5, 7)) : MODE_W'($urandom_range(4));
        case ($urandom_range(9))
          0:       count_pick = '0;
          1:       count_pick = CFG_DATA_W'(MAX_DIGITS);
          2:       count_pick = CFG_DATA_W'($urandom_range(33, 63));
          default: count_pick = CFG_DATA_W'($urandom_range(1, 12));
        endcase
        set_format({3'($urandom), mode_pick}, count_pick);
        // In the first profile, for each block up to the first one in a used mode, the receiver
        // holds off for a long stretch while values keep coming, so the input side backs up.
        if (phase == 0 && sent == 0) hold_trigger <= hold_trigger + 1;
        block_len = spare ? 3 : ITEMS_FORMAT;
        for (k = 0; k < block_len; k++) send_value(pick_value());
        if (!spare) sent += block_len;
      end
    end

    drain();
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
